// ===== src/tlbx_pkg.sv =====
// Shared types, constants and helpers for the two-level exclusive TLB.
`default_nettype none
package tlbx_pkg;

    localparam int L1_ENTRIES = 8;
    localparam int L2_ENTRIES = 32;
    localparam int PAGE_BITS  = 12;

    localparam int L1_IDX_W = (L1_ENTRIES > 1) ? $clog2(L1_ENTRIES) : 1;
    localparam int L2_IDX_W = (L2_ENTRIES > 1) ? $clog2(L2_ENTRIES) : 1;
    localparam int SCAN_W   = (L1_IDX_W > L2_IDX_W) ? L1_IDX_W : L2_IDX_W;

    localparam int VA_W    = 32;
    localparam int PN_W    = 20;
    localparam int STAMP_W = 64;
    localparam int CNT_W   = 64;
    localparam int KIND_W  = 3;
    localparam int LVL_W   = 2;
    localparam int SEL_W   = 3;
    localparam int NUM_CNT = 6;

    typedef enum logic [1:0] {
        CMD_XLATE = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_INV   = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    localparam logic [KIND_W-1:0] KIND_XLATE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MISS  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WB    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INV   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CNT   = 3'd4;

    localparam logic [LVL_W-1:0] LVL_L1   = 2'd0;
    localparam logic [LVL_W-1:0] LVL_L2   = 2'd1;
    localparam logic [LVL_W-1:0] LVL_NONE = 2'd2;

    localparam logic [SEL_W-1:0] CNT_L1_HIT  = 3'd0;
    localparam logic [SEL_W-1:0] CNT_L1_MISS = 3'd1;
    localparam logic [SEL_W-1:0] CNT_L1_INV  = 3'd2;
    localparam logic [SEL_W-1:0] CNT_L2_HIT  = 3'd3;
    localparam logic [SEL_W-1:0] CNT_L2_MISS = 3'd4;
    localparam logic [SEL_W-1:0] CNT_L2_INV  = 3'd5;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MATCH,
        OP_HIT1,
        OP_MISS,
        OP_TAKE2,
        OP_FILL1,
        OP_TAKEF,
        OP_SCAN1,
        OP_SCAN2_INIT,
        OP_SCAN2,
        OP_WB1,
        OP_WB2,
        OP_MOVE,
        OP_PLACE,
        OP_INV1,
        OP_INV2,
        OP_INVNONE,
        OP_COUNT
    } op_t;

    typedef struct packed {
        cmd_t cmd;
        logic l1_hit;
        logic l2_hit;
        logic l1_valid_p;
        logic l1_dirty_p;
        logic l2_valid_p;
        logic l2_dirty_p;
        logic scan1_last;
        logic scan2_last;
        logic out_full;
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MATCH,
        S_DISPATCH,
        S_SCAN1,
        S_VCHK,
        S_SCAN2,
        S_WBCHK,
        S_WB2,
        S_MOVE,
        S_PLACE,
        S_WB1,
        S_INV1,
        S_WB2I,
        S_INV2
    } state_t;

    // Base address of a physical frame, kept to 32 bits.
    function automatic logic [VA_W-1:0] frame_addr(input logic [PN_W-1:0] frame);
        logic [VA_W-1:0] wide;
        wide = VA_W'(frame);
        return wide << PAGE_BITS;
    endfunction

endpackage
`default_nettype wire

// ===== src/tlbx_ctrl.sv =====
// Controller state machine sequencing lookups, victim scans and result transfers.
`default_nettype none
module tlbx_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire tlbx_pkg::status_t st,
    output tlbx_pkg::op_t         op
);
    import tlbx_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath operation.
    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                op         = OP_MATCH;
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                unique case (st.cmd)
                    CMD_XLATE:
                    begin
                        if (st.l1_hit)
                        begin
                            if (!st.out_full)
                            begin
                                op         = OP_HIT1;
                                state_next = S_IDLE;
                            end
                        end
                        else if (st.l2_hit)
                        begin
                            op         = OP_TAKE2;
                            state_next = S_SCAN1;
                        end
                        else if (!st.out_full)
                        begin
                            op         = OP_MISS;
                            state_next = S_IDLE;
                        end
                    end
                    CMD_FILL:
                    begin
                        if (st.l1_hit)
                        begin
                            if (!st.out_full)
                            begin
                                op         = OP_FILL1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            op         = OP_TAKEF;
                            state_next = S_SCAN1;
                        end
                    end
                    CMD_INV:
                    begin
                        if (st.l1_hit)
                        begin
                            state_next = st.l1_dirty_p ? S_WB1 : S_INV1;
                        end
                        else if (st.l2_hit)
                        begin
                            state_next = st.l2_dirty_p ? S_WB2I : S_INV2;
                        end
                        else if (!st.out_full)
                        begin
                            op         = OP_INVNONE;
                            state_next = S_IDLE;
                        end
                    end
                    CMD_READ:
                    begin
                        if (!st.out_full)
                        begin
                            op         = OP_COUNT;
                            state_next = S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN1:
            begin
                op = OP_SCAN1;
                if (st.scan1_last)
                begin
                    state_next = S_VCHK;
                end
            end
            S_VCHK:
            begin
                if (st.l1_valid_p)
                begin
                    op         = OP_SCAN2_INIT;
                    state_next = S_SCAN2;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_SCAN2:
            begin
                op = OP_SCAN2;
                if (st.scan2_last)
                begin
                    state_next = S_WBCHK;
                end
            end
            S_WBCHK:
            begin
                state_next = (st.l2_valid_p && st.l2_dirty_p) ? S_WB2 : S_MOVE;
            end
            S_WB2:
            begin
                if (!st.out_full)
                begin
                    op         = OP_WB2;
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                op         = OP_MOVE;
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                if (!st.out_full)
                begin
                    op         = OP_PLACE;
                    state_next = S_IDLE;
                end
            end
            S_WB1:
            begin
                if (!st.out_full)
                begin
                    op         = OP_WB1;
                    state_next = S_INV1;
                end
            end
            S_INV1:
            begin
                if (!st.out_full)
                begin
                    op         = OP_INV1;
                    state_next = S_IDLE;
                end
            end
            S_WB2I:
            begin
                if (!st.out_full)
                begin
                    op         = OP_WB2;
                    state_next = S_INV2;
                end
            end
            S_INV2:
            begin
                if (!st.out_full)
                begin
                    op         = OP_INV2;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/tlbx_dp.sv =====
// Datapath: entry storage, match lanes, victim scan unit, counters and result register.
`default_nettype none
module tlbx_dp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tlbx_pkg::op_t                 op,
    output tlbx_pkg::status_t                  st,
    input  wire logic [1:0]                    command,
    input  wire logic [tlbx_pkg::VA_W-1:0]     virt_addr,
    input  wire logic                          is_write,
    input  wire logic [tlbx_pkg::PN_W-1:0]     page_number,
    input  wire logic [tlbx_pkg::PN_W-1:0]     frame_number,
    input  wire logic [tlbx_pkg::SEL_W-1:0]    counter_select,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [tlbx_pkg::KIND_W-1:0]        kind,
    output logic [tlbx_pkg::VA_W-1:0]          phys_addr,
    output logic [tlbx_pkg::LVL_W-1:0]         hit_level,
    output logic                               found,
    output logic [tlbx_pkg::CNT_W-1:0]         counter_value,
    output logic                               last
);
    import tlbx_pkg::*;

    // Captured item.
    cmd_t                 cmd_reg;
    logic [VA_W-1:0]      va_reg;
    logic                 wr_reg;
    logic [PN_W-1:0]      key_reg;
    logic [PN_W-1:0]      fill_reg;
    logic [SEL_W-1:0]     sel_reg;

    // Entry storage.
    logic                 l1_valid_reg [L1_ENTRIES];
    logic                 l1_dirty_reg [L1_ENTRIES];
    logic [PN_W-1:0]      l1_page_reg  [L1_ENTRIES];
    logic [PN_W-1:0]      l1_frame_reg [L1_ENTRIES];
    logic [STAMP_W-1:0]   l1_stamp_reg [L1_ENTRIES];
    logic                 l2_valid_reg [L2_ENTRIES];
    logic                 l2_dirty_reg [L2_ENTRIES];
    logic [PN_W-1:0]      l2_page_reg  [L2_ENTRIES];
    logic [PN_W-1:0]      l2_frame_reg [L2_ENTRIES];
    logic [STAMP_W-1:0]   l2_stamp_reg [L2_ENTRIES];

    logic [STAMP_W-1:0]   clock_reg;
    logic [CNT_W-1:0]     cnt_reg [NUM_CNT];

    // Entry pointers, match flags and the entry waiting to enter L1.
    logic [L1_IDX_W-1:0]  p1_reg;
    logic [L2_IDX_W-1:0]  p2_reg;
    logic                 l1_hit_reg;
    logic                 l2_hit_reg;
    logic [PN_W-1:0]      ne_frame_reg;
    logic                 ne_dirty_reg;
    logic [LVL_W-1:0]     ne_level_reg;

    // Victim scan unit state.
    logic [SCAN_W-1:0]    best_reg;
    logic [STAMP_W-1:0]   bstamp_reg;
    logic                 bfound_reg;

    // Result register.
    logic                 out_valid_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic [VA_W-1:0]      pa_reg;
    logic [LVL_W-1:0]     level_reg;
    logic                 found_reg;
    logic [CNT_W-1:0]     cval_reg;
    logic                 last_reg;

    logic [VA_W-1:0]      in_shift;
    logic [PN_W-1:0]      in_page;
    logic [VA_W-1:0]      offset;
    logic                 m1_hit;
    logic                 m2_hit;
    logic [L1_IDX_W-1:0]  m1_idx;
    logic [L2_IDX_W-1:0]  m2_idx;
    logic                 cur_valid;
    logic [STAMP_W-1:0]   cur_stamp;
    logic [SCAN_W-1:0]    cur_idx;
    logic                 take;
    logic [SCAN_W-1:0]    next_best;
    logic                 emit;
    logic [KIND_W-1:0]    e_kind;
    logic [VA_W-1:0]      e_pa;
    logic [LVL_W-1:0]     e_level;
    logic                 e_found;
    logic [CNT_W-1:0]     e_cval;
    logic                 e_last;

    // Page of the incoming address and page offset of the captured address.
    assign in_shift = virt_addr >> PAGE_BITS;
    assign in_page  = in_shift[PN_W-1:0];
    assign offset   = va_reg & ((VA_W'(1) << PAGE_BITS) - VA_W'(1));

    // Parallel match lanes, lowest index wins.
    always_comb
    begin
        m1_hit = 1'b0;
        m1_idx = '0;
        for (int i = L1_ENTRIES - 1; i >= 0; i--)
        begin
            if (l1_valid_reg[i] && (l1_page_reg[i] == key_reg))
            begin
                m1_hit = 1'b1;
                m1_idx = L1_IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        m2_hit = 1'b0;
        m2_idx = '0;
        for (int i = L2_ENTRIES - 1; i >= 0; i--)
        begin
            if (l2_valid_reg[i] && (l2_page_reg[i] == key_reg))
            begin
                m2_hit = 1'b1;
                m2_idx = L2_IDX_W'(i);
            end
        end
    end

    // Scan step: an invalid entry ends the search, else the smallest stamp wins.
    always_comb
    begin
        if (op == OP_SCAN2)
        begin
            cur_valid = l2_valid_reg[p2_reg];
            cur_stamp = l2_stamp_reg[p2_reg];
            cur_idx   = SCAN_W'(p2_reg);
        end
        else
        begin
            cur_valid = l1_valid_reg[p1_reg];
            cur_stamp = l1_stamp_reg[p1_reg];
            cur_idx   = SCAN_W'(p1_reg);
        end
        take      = !bfound_reg && (!cur_valid || (cur_stamp < bstamp_reg));
        next_best = take ? cur_idx : best_reg;
    end

    // Status toward the controller.
    always_comb
    begin
        st.cmd        = cmd_reg;
        st.l1_hit     = l1_hit_reg;
        st.l2_hit     = l2_hit_reg;
        st.l1_valid_p = l1_valid_reg[p1_reg];
        st.l1_dirty_p = l1_dirty_reg[p1_reg];
        st.l2_valid_p = l2_valid_reg[p2_reg];
        st.l2_dirty_p = l2_dirty_reg[p2_reg];
        st.scan1_last = (p1_reg == L1_IDX_W'(L1_ENTRIES - 1));
        st.scan2_last = (p2_reg == L2_IDX_W'(L2_ENTRIES - 1));
        st.out_full   = out_valid_reg;
    end

    // Result produced by the current operation, if any.
    always_comb
    begin
        emit    = 1'b1;
        e_kind  = KIND_XLATE;
        e_pa    = '0;
        e_level = LVL_NONE;
        e_found = 1'b0;
        e_cval  = '0;
        e_last  = 1'b1;
        unique case (op)
            OP_HIT1:
            begin
                e_pa    = frame_addr(l1_frame_reg[p1_reg]) | offset;
                e_level = LVL_L1;
            end
            OP_FILL1:
            begin
                e_pa = frame_addr(fill_reg) | offset;
            end
            OP_PLACE:
            begin
                e_pa    = frame_addr(ne_frame_reg) | offset;
                e_level = ne_level_reg;
            end
            OP_MISS:
            begin
                e_kind = KIND_MISS;
            end
            OP_WB1:
            begin
                e_kind = KIND_WB;
                e_pa   = frame_addr(l1_frame_reg[p1_reg]);
                e_last = 1'b0;
            end
            OP_WB2:
            begin
                e_kind = KIND_WB;
                e_pa   = frame_addr(l2_frame_reg[p2_reg]);
                e_last = 1'b0;
            end
            OP_INV1:
            begin
                e_kind  = KIND_INV;
                e_level = LVL_L1;
                e_found = 1'b1;
            end
            OP_INV2:
            begin
                e_kind  = KIND_INV;
                e_level = LVL_L2;
                e_found = 1'b1;
            end
            OP_INVNONE:
            begin
                e_kind = KIND_INV;
            end
            OP_COUNT:
            begin
                e_kind = KIND_CNT;
                e_cval = (sel_reg < SEL_W'(NUM_CNT)) ? cnt_reg[sel_reg] : '0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Result register: loaded by an emitting operation, emptied by a transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg  <= e_kind;
            pa_reg    <= e_pa;
            level_reg <= e_level;
            found_reg <= e_found;
            cval_reg  <= e_cval;
            last_reg  <= e_last;
        end
    end

    // Control state: valid bits, access clock, counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < L1_ENTRIES; i++)
            begin
                l1_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < L2_ENTRIES; i++)
            begin
                l2_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < NUM_CNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
            clock_reg <= '0;
        end
        else
        begin
            unique case (op)
                OP_MATCH:
                begin
                    if (cmd_reg == CMD_XLATE || cmd_reg == CMD_FILL)
                    begin
                        clock_reg <= clock_reg + 1'b1;
                    end
                end
                OP_HIT1:
                begin
                    cnt_reg[CNT_L1_HIT] <= cnt_reg[CNT_L1_HIT] + 1'b1;
                end
                OP_MISS:
                begin
                    cnt_reg[CNT_L1_MISS] <= cnt_reg[CNT_L1_MISS] + 1'b1;
                    cnt_reg[CNT_L2_MISS] <= cnt_reg[CNT_L2_MISS] + 1'b1;
                end
                OP_TAKE2:
                begin
                    cnt_reg[CNT_L1_MISS] <= cnt_reg[CNT_L1_MISS] + 1'b1;
                    cnt_reg[CNT_L2_HIT]  <= cnt_reg[CNT_L2_HIT] + 1'b1;
                    l2_valid_reg[p2_reg] <= 1'b0;
                end
                OP_TAKEF:
                begin
                    if (l2_hit_reg)
                    begin
                        l2_valid_reg[p2_reg] <= 1'b0;
                    end
                end
                OP_MOVE:
                begin
                    l2_valid_reg[p2_reg] <= 1'b1;
                end
                OP_PLACE:
                begin
                    l1_valid_reg[p1_reg] <= 1'b1;
                end
                OP_INV1:
                begin
                    l1_valid_reg[p1_reg] <= 1'b0;
                    cnt_reg[CNT_L1_INV]  <= cnt_reg[CNT_L1_INV] + 1'b1;
                end
                OP_INV2:
                begin
                    l2_valid_reg[p2_reg] <= 1'b0;
                    cnt_reg[CNT_L2_INV]  <= cnt_reg[CNT_L2_INV] + 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload state: captured item, entry contents, pointers and scan unit.
    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_LOAD:
            begin
                cmd_reg  <= cmd_t'(command);
                va_reg   <= virt_addr;
                wr_reg   <= is_write;
                key_reg  <= (cmd_t'(command) == CMD_INV) ? page_number : in_page;
                fill_reg <= frame_number;
                sel_reg  <= counter_select;
            end
            OP_MATCH:
            begin
                l1_hit_reg <= m1_hit;
                l2_hit_reg <= m2_hit;
                p1_reg     <= m1_idx;
                p2_reg     <= m2_idx;
            end
            OP_HIT1:
            begin
                l1_stamp_reg[p1_reg] <= clock_reg;
                if (wr_reg)
                begin
                    l1_dirty_reg[p1_reg] <= 1'b1;
                end
            end
            OP_FILL1:
            begin
                l1_frame_reg[p1_reg] <= fill_reg;
                l1_dirty_reg[p1_reg] <= l1_dirty_reg[p1_reg] | wr_reg;
                l1_stamp_reg[p1_reg] <= clock_reg;
            end
            OP_TAKE2:
            begin
                ne_frame_reg <= l2_frame_reg[p2_reg];
                ne_dirty_reg <= l2_dirty_reg[p2_reg] | wr_reg;
                ne_level_reg <= LVL_L2;
                p1_reg       <= '0;
                best_reg     <= '0;
                bstamp_reg   <= '1;
                bfound_reg   <= 1'b0;
            end
            OP_TAKEF:
            begin
                ne_frame_reg <= fill_reg;
                ne_dirty_reg <= wr_reg | (l2_hit_reg & l2_dirty_reg[p2_reg]);
                ne_level_reg <= LVL_NONE;
                p1_reg       <= '0;
                best_reg     <= '0;
                bstamp_reg   <= '1;
                bfound_reg   <= 1'b0;
            end
            OP_SCAN1:
            begin
                if (take)
                begin
                    best_reg   <= cur_idx;
                    bstamp_reg <= cur_stamp;
                    bfound_reg <= !cur_valid;
                end
                if (p1_reg == L1_IDX_W'(L1_ENTRIES - 1))
                begin
                    p1_reg <= next_best[L1_IDX_W-1:0];
                end
                else
                begin
                    p1_reg <= p1_reg + 1'b1;
                end
            end
            OP_SCAN2_INIT:
            begin
                p2_reg     <= '0;
                best_reg   <= '0;
                bstamp_reg <= '1;
                bfound_reg <= 1'b0;
            end
            OP_SCAN2:
            begin
                if (take)
                begin
                    best_reg   <= cur_idx;
                    bstamp_reg <= cur_stamp;
                    bfound_reg <= !cur_valid;
                end
                if (p2_reg == L2_IDX_W'(L2_ENTRIES - 1))
                begin
                    p2_reg <= next_best[L2_IDX_W-1:0];
                end
                else
                begin
                    p2_reg <= p2_reg + 1'b1;
                end
            end
            OP_MOVE:
            begin
                l2_dirty_reg[p2_reg] <= l1_dirty_reg[p1_reg];
                l2_page_reg[p2_reg]  <= l1_page_reg[p1_reg];
                l2_frame_reg[p2_reg] <= l1_frame_reg[p1_reg];
                l2_stamp_reg[p2_reg] <= l1_stamp_reg[p1_reg];
            end
            OP_PLACE:
            begin
                l1_dirty_reg[p1_reg] <= ne_dirty_reg;
                l1_page_reg[p1_reg]  <= key_reg;
                l1_frame_reg[p1_reg] <= ne_frame_reg;
                l1_stamp_reg[p1_reg] <= clock_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign phys_addr     = pa_reg;
    assign hit_level     = level_reg;
    assign found         = found_reg;
    assign counter_value = cval_reg;
    assign last          = last_reg;

endmodule
`default_nettype wire

// ===== src/two_level_exclusive_tlb.sv =====
// An L1 hit, a miss, a fill of an L1 page, a counter read and an invalidate that finds nothing
// load their result in the dispatch state; an invalidate that finds an entry loads it in an
// invalidate state, after a writeback result in a writeback state when the entry is dirty.
// A move into L1 scans all L1 entries for a victim; a valid L1 victim moves into the L2 slot
// found by a scan of all L2 entries, after a writeback when that L2 entry is valid and dirty.
// One item is in work at a time; the next transfer is taken in the cycle after the final result
// is loaded. Reset clears all valid bits, the access clock and the statistics counters at once.
`default_nettype none
module two_level_exclusive_tlb (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    command,
    input  wire logic [tlbx_pkg::VA_W-1:0]     virt_addr,
    input  wire logic                          is_write,
    input  wire logic [tlbx_pkg::PN_W-1:0]     page_number,
    input  wire logic [tlbx_pkg::PN_W-1:0]     frame_number,
    input  wire logic [tlbx_pkg::SEL_W-1:0]    counter_select,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [tlbx_pkg::KIND_W-1:0]        kind,
    output logic [tlbx_pkg::VA_W-1:0]          phys_addr,
    output logic [tlbx_pkg::LVL_W-1:0]         hit_level,
    output logic                               found,
    output logic [tlbx_pkg::CNT_W-1:0]         counter_value,
    output logic                               last
);
    import tlbx_pkg::*;

    op_t     op;
    status_t st;

    // Sequencer.
    tlbx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .op       (op)
    );

    // Storage and result datapath.
    tlbx_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .op             (op),
        .st             (st),
        .command        (command),
        .virt_addr      (virt_addr),
        .is_write       (is_write),
        .page_number    (page_number),
        .frame_number   (frame_number),
        .counter_select (counter_select),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .phys_addr      (phys_addr),
        .hit_level      (hit_level),
        .found          (found),
        .counter_value  (counter_value),
        .last           (last)
    );

endmodule
`default_nettype wire
